// ===== rtl/core/bounded_fifo_sjn_request_queue_core_defines.svh =====
// Assertion macros for the request queue core.
// Expects clk_i and rst_ni in the scope of use; no other dependencies.
`ifndef BOUNDED_FIFO_SJN_REQUEST_QUEUE_CORE_DEFINES_SVH
`define BOUNDED_FIFO_SJN_REQUEST_QUEUE_CORE_DEFINES_SVH

// Property holds at every edge outside reset.
`define BFSQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define BFSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bfsq_pkg.sv =====
// Shared types and constants of the request queue core.
// No dependencies.
package bfsq_pkg;

  localparam int ID_W     = 32;
  localparam int LEN_W    = 32;
  localparam int OCC_W    = 5;
  localparam int LIMIT_W  = 5;
  localparam int CFG_DATA_W = 5;
  localparam int LIMIT_RESET = 16;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic {
    MODE_FIFO = 1'b0,
    MODE_SJN  = 1'b1
  } mode_e;

  typedef enum logic {
    CFG_ORDER_MODE  = 1'b0,
    CFG_QUEUE_LIMIT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_POP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [LEN_W-1:0] len;
  } entry_t;

endpackage

// ===== rtl/core/bfsq_if.sv =====
// Channel interfaces of the request queue core: request, response, config.
// Depends on bfsq_pkg.
interface bfsq_req_if;
  import bfsq_pkg::*;
  logic              valid;
  logic              ready;
  op_e               opcode;
  logic [ID_W-1:0]   request_id;
  logic [LEN_W-1:0]  job_length;
  modport source (output valid, opcode, request_id, job_length, input ready);
  modport sink   (input valid, opcode, request_id, job_length, output ready);
endinterface

interface bfsq_rsp_if;
  import bfsq_pkg::*;
  logic              valid;
  logic              ready;
  status_e           status;
  logic [ID_W-1:0]   popped_id;
  logic [LEN_W-1:0]  popped_length;
  logic [OCC_W-1:0]  occupancy;
  modport source (output valid, status, popped_id, popped_length, occupancy, input ready);
  modport sink   (input valid, status, popped_id, popped_length, occupancy, output ready);
endinterface

interface bfsq_cfg_if;
  import bfsq_pkg::*;
  logic                  valid;
  logic                  ready;
  cfg_reg_e              index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/bounded_fifo_sjn_request_queue_core.sv =====
// Bounded request queue, FIFO or shortest-job-next order, over a ring store.
// Depends on bfsq_pkg, bfsq_if.sv and bounded_fifo_sjn_request_queue_core_defines.svh.
// One beat in, one beat out per request; one request is worked on at a time. A rejected
// enqueue, an empty dequeue, a FIFO enqueue and an enqueue onto an empty queue are settled
// in the idle state; a dequeue first reads the head entry (registered store read). A
// shortest-job-next enqueue onto a non-empty queue walks the entry store from the head,
// one read and one compare/write-back per entry, carrying displaced entries one slot
// toward the tail. A new request is taken while the previous response still waits in
// the output register.
`include "bounded_fifo_sjn_request_queue_core_defines.svh"

module bounded_fifo_sjn_request_queue_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bfsq_cfg_if.sink   cfg_i,
  bfsq_req_if.sink   req_i,
  bfsq_rsp_if.source rsp_o
);
  import bfsq_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int SUM_W = ((IDX_W > OCC_W) ? IDX_W : OCC_W) + 1;

  // Configuration
  mode_e              mode_q;
  logic [LIMIT_W-1:0] limit_q;

  // Queue control
  state_e             state_q, state_d;
  logic [IDX_W-1:0]   head_q, head_d;
  logic [IDX_W-1:0]   tail_q, tail_d;
  logic [OCC_W-1:0]   count_q, count_d;
  logic [OCC_W-1:0]   scan_q, scan_d;
  logic               ins_q, ins_d;
  entry_t             carry_q, carry_d;

  // Pending response
  status_e            res_status_q, res_status_d;
  entry_t             res_entry_q, res_entry_d;

  // Output register
  logic               out_valid_q, out_valid_d;
  status_e            out_status_q, out_status_d;
  entry_t             out_entry_q, out_entry_d;
  logic [OCC_W-1:0]   out_occ_q, out_occ_d;

  // Entry store
  entry_t             entry_mem [QUEUE_DEPTH];
  entry_t             mem_rdata_q;
  logic               mem_we, mem_re;
  logic [IDX_W-1:0]   mem_waddr, mem_raddr;
  entry_t             mem_wdata;

  logic               req_fire, out_free, full;
  logic [SUM_W-1:0]   addr_sum, addr_wrap, eff_limit, depth_w;
  logic [IDX_W-1:0]   scan_addr;
  entry_t             req_entry;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : p + IDX_W'(1);
  endfunction

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_FIFO;
      limit_q <= LIMIT_W'(LIMIT_RESET);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_ORDER_MODE:  mode_q  <= mode_e'(cfg_i.data[0]);
        CFG_QUEUE_LIMIT: limit_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign depth_w   = SUM_W'(QUEUE_DEPTH);
  assign eff_limit = (SUM_W'(limit_q) > depth_w) ? depth_w : SUM_W'(limit_q);
  assign full      = SUM_W'(count_q) >= eff_limit;

  // Ring position of the scan offset
  assign addr_sum  = SUM_W'(head_q) + SUM_W'(scan_q);
  assign addr_wrap = (addr_sum >= depth_w) ? addr_sum - depth_w : addr_sum;
  assign scan_addr = addr_wrap[IDX_W-1:0];

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign req_entry   = '{id: req_i.request_id, len: req_i.job_length};

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    scan_d       = scan_q;
    ins_d        = ins_q;
    carry_d      = carry_q;
    res_status_d = res_status_q;
    res_entry_d  = res_entry_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_entry_d  = out_entry_q;
    out_occ_d    = out_occ_q;
    mem_we       = 1'b0;
    mem_waddr    = tail_q;
    mem_wdata    = req_entry;
    mem_re       = 1'b0;
    mem_raddr    = head_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          res_status_d = ST_DONE;
          res_entry_d  = '0;
          state_d      = S_DONE;
          if (req_i.opcode == OP_ENQ) begin
            if (full) begin
              res_status_d = ST_FULL;
            end else if (mode_q == MODE_FIFO || count_q == '0) begin
              mem_we  = 1'b1;
              count_d = count_q + OCC_W'(1);
              tail_d  = ring_next(tail_q);
            end else begin
              carry_d = req_entry;
              ins_d   = 1'b0;
              scan_d  = '0;
              state_d = S_SCAN_RD;
            end
          end else begin
            if (count_q == '0) begin
              res_status_d = ST_EMPTY;
            end else begin
              mem_re  = 1'b1;
              state_d = S_POP;
            end
          end
        end
      end
      S_SCAN_RD: begin
        if (scan_q == count_q) begin
          // Past the last held entry: drop the carried entry here
          mem_we    = 1'b1;
          mem_waddr = scan_addr;
          mem_wdata = carry_q;
          count_d   = count_q + OCC_W'(1);
          tail_d    = ring_next(scan_addr);
          state_d   = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = scan_addr;
          state_d   = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (ins_q || mem_rdata_q.len > carry_q.len) begin
          mem_we    = 1'b1;
          mem_waddr = scan_addr;
          mem_wdata = carry_q;
          carry_d   = mem_rdata_q;
          ins_d     = 1'b1;
        end
        scan_d  = scan_q + OCC_W'(1);
        state_d = S_SCAN_RD;
      end
      S_POP: begin
        res_entry_d = mem_rdata_q;
        head_d      = ring_next(head_q);
        count_d     = count_q - OCC_W'(1);
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_entry_d  = res_entry_q;
          out_occ_d    = count_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      scan_q      <= '0;
      ins_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      ins_q       <= ins_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q      <= carry_d;
    res_status_q <= res_status_d;
    res_entry_q  <= res_entry_d;
    out_status_q <= out_status_d;
    out_entry_q  <= out_entry_d;
    out_occ_q    <= out_occ_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= entry_mem[mem_raddr];
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.popped_id     = out_entry_q.id;
  assign rsp_o.popped_length = out_entry_q.len;
  assign rsp_o.occupancy     = out_occ_q;

  `BFSQ_ASSERT(a_count_in_depth, SUM_W'(count_q) <= depth_w, "entry count exceeds store depth")
  `BFSQ_ASSERT(a_scan_in_range, (state_q != S_SCAN_CMP) || (scan_q < count_q),
               "scan past held entries")
  `BFSQ_ASSERT(a_no_write_on_pop, (state_q != S_POP) || !mem_we, "store written during pop")
  `BFSQ_ASSERT_NEXT(a_count_step, 1'b1,
                    (count_q == $past(count_q)) ||
                    (count_q == $past(count_q) + OCC_W'(1)) ||
                    (count_q == $past(count_q) - OCC_W'(1)),
                    "entry count moved by more than one")

endmodule
